// File: hw/rtl/lcd_spi_command_framer_macros.svh
// ----------------------------------------------------------------------------
// LCD SPI command framer assertion macros
// Shared concurrent assertion wrappers, clocked on clk, reset on rst_n.
// ----------------------------------------------------------------------------
`ifndef LCD_SPI_COMMAND_FRAMER_MACROS_SVH
`define LCD_SPI_COMMAND_FRAMER_MACROS_SVH

// Assertion that is ignored while reset is held
`define LCF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assertion that is also checked across reset
`define LCF_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/lcf_pkg.sv
// ----------------------------------------------------------------------------
// LCD SPI command framer package
// Request codes, display command bytes, queue entry type and byte decoder.
// ----------------------------------------------------------------------------
package lcf_pkg;

  localparam int REQ_W  = 2;
  localparam int WORD_W = 16;
  localparam int BYTE_W = 8;
  localparam int IDX_W  = 4;

  // Request kinds
  localparam logic [REQ_W-1:0] REQ_CMD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PARAM = 2'd1;
  localparam logic [REQ_W-1:0] REQ_WORD  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_POINT = 2'd3;

  // Display controller commands
  localparam logic [BYTE_W-1:0] LCD_CMD_COLUMN   = 8'h2A;
  localparam logic [BYTE_W-1:0] LCD_CMD_ROW      = 8'h2B;
  localparam logic [BYTE_W-1:0] LCD_CMD_MEMWRITE = 8'h2C;

  // Index of the final byte for each request kind
  localparam logic [IDX_W-1:0] LAST_IDX_BYTE  = 4'd0;
  localparam logic [IDX_W-1:0] LAST_IDX_WORD  = 4'd1;
  localparam logic [IDX_W-1:0] LAST_IDX_POINT = 4'd12;

  // Classified request as it travels from front to back
  typedef struct packed {
    logic [REQ_W-1:0]  kind;
    logic [IDX_W-1:0]  last_idx;
    logic [WORD_W-1:0] value;
    logic [WORD_W-1:0] x_pos;
    logic [WORD_W-1:0] y_pos;
  } lcf_req_t;

  // One link byte with its side flags
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              is_data;
    logic              cs_release;
  } lcf_byte_t;

  // Number of bytes minus one for a request kind
  function automatic logic [IDX_W-1:0] lcf_last_idx(input logic [REQ_W-1:0] kind);
    logic [IDX_W-1:0] res;
    unique case (kind)
      REQ_CMD:   res = LAST_IDX_BYTE;
      REQ_PARAM: res = LAST_IDX_BYTE;
      REQ_WORD:  res = LAST_IDX_WORD;
      default:   res = LAST_IDX_POINT;
    endcase
    return res;
  endfunction

  // Byte at position idx of a point write
  function automatic lcf_byte_t lcf_point_byte(input lcf_req_t req,
                                               input logic [IDX_W-1:0] idx);
    lcf_byte_t b;
    unique case (idx) inside
      4'd0:        b = '{data: LCD_CMD_COLUMN, is_data: 1'b0, cs_release: 1'b1};
      4'd1, 4'd3:  b = '{data: req.x_pos[15:8], is_data: 1'b1, cs_release: 1'b0};
      4'd2, 4'd4:  b = '{data: req.x_pos[7:0],  is_data: 1'b1, cs_release: 1'b1};
      4'd5:        b = '{data: LCD_CMD_ROW,    is_data: 1'b0, cs_release: 1'b1};
      4'd6, 4'd8:  b = '{data: req.y_pos[15:8], is_data: 1'b1, cs_release: 1'b0};
      4'd7, 4'd9:  b = '{data: req.y_pos[7:0],  is_data: 1'b1, cs_release: 1'b1};
      4'd10:       b = '{data: LCD_CMD_MEMWRITE, is_data: 1'b0, cs_release: 1'b1};
      4'd11:       b = '{data: req.value[15:8], is_data: 1'b1, cs_release: 1'b0};
      default:     b = '{data: req.value[7:0],  is_data: 1'b1, cs_release: 1'b1};
    endcase
    return b;
  endfunction

  // Byte at position idx of any request
  function automatic lcf_byte_t lcf_byte_gen(input lcf_req_t req,
                                             input logic [IDX_W-1:0] idx);
    lcf_byte_t b;
    unique case (req.kind)
      REQ_CMD:   b = '{data: req.value[7:0], is_data: 1'b0, cs_release: 1'b1};
      REQ_PARAM: b = '{data: req.value[7:0], is_data: 1'b1, cs_release: 1'b1};
      REQ_WORD: begin
        if (idx == 4'd0) begin
          b = '{data: req.value[15:8], is_data: 1'b1, cs_release: 1'b0};
        end else begin
          b = '{data: req.value[7:0], is_data: 1'b1, cs_release: 1'b1};
        end
      end
      default:   b = lcf_point_byte(req, idx);
    endcase
    return b;
  endfunction

endpackage

// File: hw/rtl/lcd_spi_command_framer.sv
// ----------------------------------------------------------------------------
// LCD SPI command framer
// Turns display write requests into flagged bytes for a serial LCD link.
// ----------------------------------------------------------------------------
// Channel   Direction  tdata                             tuser
// in_       slave      value, x_pos, y_pos (48 bits)     req_type
// out_      master     out_byte (8 bits)                 is_data, cs_release
//
// One byte leaves per cycle when out_tready is high and a request waits: a
// command or parameter request yields 1 byte, a data word 2, a point write
// 13, paced by the byte sequencer. Accepted requests pass through the front
// register, the two-entry queue and the output register. Synchronous
// active-low reset empties the queue and output register. A stalled output
// blocks the input only once both the queue and the front register fill.
// ----------------------------------------------------------------------------
module lcd_spi_command_framer
  import lcf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [15:0] value, [31:16] x_pos, [47:32] y_pos
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic [1:0]  out_tuser,  // [0] is_data, [1] cs_release
  output logic        out_tlast
);

  logic      fq_valid;
  logic      fq_ready;
  lcf_req_t  fq_req;
  logic      qb_valid;
  logic      qb_ready;
  lcf_req_t  qb_req;
  lcf_byte_t out_word;

  // Accept and classify
  lcf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_kind   (in_tuser),
    .in_value  (in_tdata[15:0]),
    .in_x_pos  (in_tdata[31:16]),
    .in_y_pos  (in_tdata[47:32]),
    .req_valid (fq_valid),
    .req_ready (fq_ready),
    .req       (fq_req)
  );

  // Decouple front and back
  lcf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_req   (fq_req),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_req    (qb_req)
  );

  // Sequence bytes
  lcf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (qb_valid),
    .req_ready (qb_ready),
    .req       (qb_req),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_word),
    .out_last  (out_tlast)
  );

  assign out_tdata = out_word.data;
  assign out_tuser = {out_word.cs_release, out_word.is_data};

endmodule

// File: hw/rtl/lcf_front.sv
// ----------------------------------------------------------------------------
// LCD SPI command framer front end
// Accepts request words, tags them with their last byte index, feeds the queue.
// ----------------------------------------------------------------------------
module lcf_front
  import lcf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [15:0] in_value,
  input  logic [15:0] in_x_pos,
  input  logic [15:0] in_y_pos,
  output logic        req_valid,
  input  logic        req_ready,
  output lcf_req_t    req
);

  logic     vld_r;
  logic     vld_nxt;
  lcf_req_t req_r;
  logic     take;

  // Take a new word when the stage is empty or drains this cycle
  assign in_ready = !vld_r || req_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (req_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Classify and hold the payload
  always_ff @(posedge clk) begin
    if (take) begin
      req_r.kind     <= in_kind;
      req_r.last_idx <= lcf_last_idx(in_kind);
      req_r.value    <= in_value;
      req_r.x_pos    <= in_x_pos;
      req_r.y_pos    <= in_y_pos;
    end
  end

  assign req_valid = vld_r;
  assign req       = req_r;

endmodule

// File: hw/rtl/lcf_queue.sv
// ----------------------------------------------------------------------------
// LCD SPI command framer request queue
// Two-entry FIFO between front end and byte sequencer.
// ----------------------------------------------------------------------------
module lcf_queue
  import lcf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  lcf_req_t push_req,
  output logic     pop_valid,
  input  logic     pop_ready,
  output lcf_req_t pop_req
);

  lcf_req_t   entry_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       push;
  logic       pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_req    = entry_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_req;
    end
  end

endmodule

// File: hw/rtl/lcf_back.sv
// ----------------------------------------------------------------------------
// LCD SPI command framer byte sequencer
// Walks the head request byte by byte into the output register.
// ----------------------------------------------------------------------------
module lcf_back
  import lcf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       req_valid,
  output logic       req_ready,
  input  lcf_req_t   req,
  output logic       out_valid,
  input  logic       out_ready,
  output lcf_byte_t  out_byte,
  output logic       out_last
);

  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;
  logic             vld_r;
  logic             vld_nxt;
  lcf_byte_t        byte_r;
  logic             last_r;
  logic             load;
  logic             at_end;

  // Emit a byte whenever a request waits and the output register is free or drains
  assign load      = req_valid && (!vld_r || out_ready);
  assign at_end    = (idx_r == req.last_idx);
  assign req_ready = load && at_end;

  always_comb begin
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = at_end ? '0 : idx_r + 4'd1;
    end
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  // Hold the byte and its flags
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= lcf_byte_gen(req, idx_r);
      last_r <= at_end;
    end
  end

  assign out_valid = vld_r;
  assign out_byte  = byte_r;
  assign out_last  = last_r;

endmodule

// File: hw/rtl/lcf_checker.sv
// ----------------------------------------------------------------------------
// LCD SPI command framer port checker
// Watches the top-level ports for framing and handshake slips.
// ----------------------------------------------------------------------------
`include "lcd_spi_command_framer_macros.svh"

module lcf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // Output word holds while stalled
  `LCF_ASSERT(a_out_hold,
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast),
    "output word changed under stall")

  // Nothing is offered right after reset
  `LCF_ASSERT_RST(a_reset_idle, !rst_n |=> !out_tvalid,
    "output valid right after reset")

  // The final word of a request always releases chip select
  `LCF_ASSERT(a_last_release, out_tvalid && out_tlast |-> out_tuser[1],
    "last word without chip select release")

  // Command words always release chip select
  `LCF_ASSERT(a_cmd_release, out_tvalid && !out_tuser[0] |-> out_tuser[1],
    "command word without chip select release")

endmodule

bind lcd_spi_command_framer lcf_checker u_lcf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LCD SPI command framer testbench
// Sends command, parameter, data word and point write requests with random
// gaps, predicts the flagged link bytes of each accepted request and checks
// every output word in order against them under random output stalls.
// ----------------------------------------------------------------------------
module tb;
  import lcf_pkg::*;

  // One expected link byte with its flags
  typedef struct packed {
    logic [7:0] data;
    logic       is_data;
    logic       cs_release;
    logic       last;
  } link_byte_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;   // [15:0] value, [31:16] x_pos, [47:32] y_pos
  logic [1:0]  in_tuser   = '0;   // [1:0] req_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // [7:0] out_byte
  logic [1:0]  out_tuser;         // [0] is_data, [1] cs_release
  logic        out_tlast;

  link_byte_t  link_bytes_due[$];
  int          fail_count = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;

  lcd_spi_command_framer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #4 clk = ~clk;

  // Stall the output side at random while idling is enabled
  always @(posedge clk) begin
    out_tready <= !rx_idle_on || ($urandom_range(99) >= 29);
  end

  // Append one link byte to the expected stream
  task automatic due_byte(input logic [7:0] b, input logic dc, input logic cs);
    link_bytes_due.push_back('{data: b, is_data: dc, cs_release: cs, last: 1'b0});
  endtask

  // Append a 16-bit word, high byte first, chip select released after low byte
  task automatic due_word(input logic [15:0] w);
    due_byte(w[15:8], 1'b1, 1'b0);
    due_byte(w[7:0], 1'b1, 1'b1);
  endtask

  // Predict the byte sequence of one accepted request
  task automatic frame_request(input logic [1:0] kind, input logic [15:0] value,
                               input logic [15:0] x_pos, input logic [15:0] y_pos);
    case (kind)
      REQ_CMD:   due_byte(value[7:0], 1'b0, 1'b1);
      REQ_PARAM: due_byte(value[7:0], 1'b1, 1'b1);
      REQ_WORD:  due_word(value);
      default: begin
        due_byte(LCD_CMD_COLUMN, 1'b0, 1'b1);
        due_word(x_pos);
        due_word(x_pos);
        due_byte(LCD_CMD_ROW, 1'b0, 1'b1);
        due_word(y_pos);
        due_word(y_pos);
        due_byte(LCD_CMD_MEMWRITE, 1'b0, 1'b1);
        due_word(value);
      end
    endcase
    link_bytes_due[link_bytes_due.size()-1].last = 1'b1;
  endtask

  // Offer one request, hold it until in_tready is seen high after an edge, then record its bytes.
  // Entered and left just after a rising edge; valid is left high.
  task automatic send_req(input logic [1:0] kind, input logic [15:0] value,
                          input logic [15:0] x_pos, input logic [15:0] y_pos);
    while (tx_idle_on && ($urandom_range(99) < 29)) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {y_pos, x_pos, value};
    in_tuser  <= kind;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    frame_request(kind, value, x_pos, y_pos);
  endtask

  // Lower valid and hold until every predicted byte has left the block
  task automatic drain_link;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (link_bytes_due.size() != 0) @(posedge clk);
  endtask

  // Random 16-bit field, biased toward the extremes
  function automatic logic [15:0] rand_field;
    logic [15:0] v;
    case ($urandom_range(7))
      0:       v = 16'h0000;
      1:       v = 16'hFFFF;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  // Command bytes: high byte of value and coordinates must be ignored
  task automatic test_command_bytes;
    send_req(REQ_CMD, 16'h0000, 16'hFFFF, 16'hFFFF);
    send_req(REQ_CMD, 16'hFFFF, 16'h0000, 16'h0000);
    send_req(REQ_CMD, 16'hFF00, 16'h1234, 16'h5678);
    send_req(REQ_CMD, 16'h00FF, 16'hA5A5, 16'h5A5A);
  endtask

  // Parameter bytes: same masking as commands, data/command line high
  task automatic test_param_bytes;
    send_req(REQ_PARAM, 16'h0000, 16'hFFFF, 16'h0000);
    send_req(REQ_PARAM, 16'hFFFF, 16'h0000, 16'hFFFF);
    send_req(REQ_PARAM, 16'hAB80, 16'h8000, 16'h0001);
    send_req(REQ_PARAM, 16'h0001, 16'h7FFF, 16'hFFFE);
  endtask

  // Data words: high byte first, coordinates ignored
  task automatic test_data_words;
    send_req(REQ_WORD, 16'h0000, 16'hFFFF, 16'hFFFF);
    send_req(REQ_WORD, 16'hFFFF, 16'h0000, 16'h0000);
    send_req(REQ_WORD, 16'h8001, 16'h1111, 16'h2222);
    send_req(REQ_WORD, 16'h7FFE, 16'hEEEE, 16'hDDDD);
  endtask

  // Point writes at the coordinate and color extremes and at mid values
  task automatic test_point_writes;
    send_req(REQ_POINT, 16'h0000, 16'h0000, 16'h0000);
    send_req(REQ_POINT, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_req(REQ_POINT, 16'h55AA, 16'h1234, 16'hABCD);
    send_req(REQ_POINT, 16'hF800, 16'h00EF, 16'h013F);
  endtask

  // Random mix of all request kinds
  task automatic test_random_traffic(input int n_items);
    for (int i = 0; i < n_items; i++) begin
      send_req(2'($urandom_range(3)), rand_field(), rand_field(), rand_field());
    end
  endtask

  // Pause the sender until the link is empty, then resume
  task automatic test_drain_pause;
    test_random_traffic(6);
    drain_link();
    test_random_traffic(6);
    drain_link();
    send_req(REQ_POINT, rand_field(), rand_field(), rand_field());
  endtask

  // Back-to-back traffic with neither side idling
  task automatic test_no_idle_burst(input int n_items);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random_traffic(n_items);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Check each output word against the oldest predicted byte
  always @(posedge clk) begin : check_link_byte
    link_byte_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (link_bytes_due.size() == 0) begin
        $error("unexpected output byte %02h", out_tdata);
        fail_count++;
      end else begin
        want = link_bytes_due.pop_front();
        if (out_tdata !== want.data) begin
          $error("out_byte: expected %02h, got %02h", want.data, out_tdata);
          fail_count++;
        end
        if (out_tuser[0] !== want.is_data) begin
          $error("is_data: expected %0b, got %0b", want.is_data, out_tuser[0]);
          fail_count++;
        end
        if (out_tuser[1] !== want.cs_release) begin
          $error("cs_release: expected %0b, got %0b", want.cs_release, out_tuser[1]);
          fail_count++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_tlast);
          fail_count++;
        end
      end
    end
  end

  // Run the tests in turn
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_command_bytes();
    test_param_bytes();
    test_data_words();
    test_point_writes();
    test_random_traffic(200);
    test_drain_pause();
    test_no_idle_burst(100);
    test_random_traffic(140);

    // Wait out the remaining bytes and watch for strays
    drain_link();
    repeat (20) @(posedge clk);
    if (link_bytes_due.size() != 0) begin
      $error("%0d predicted bytes never arrived", link_bytes_due.size());
      fail_count++;
    end

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
